>>> hdl/sdrc_pkg.sv
// shared types and constants for the stick dead-zone and radial clamp core
package sdrc_pkg;

   // field widths fixed by the sample format
   localparam int RAW_W  = 16;
   localparam int OUT_W  = 16;
   localparam int CSR_W  = 15;

   // register reset values
   localparam logic [CSR_W-1:0] DEAD_ZONE_RESET  = 15'd3000;
   localparam logic [CSR_W-1:0] FULL_SCALE_RESET = 15'd25000;

   // register indexes
   typedef enum logic [0:0] {
      CSR_DEAD_ZONE  = 1'b0,
      CSR_FULL_SCALE = 1'b1
   } csr_index_type;

   // input beat
   typedef struct packed {
      logic signed [RAW_W-1:0] raw_x;
      logic signed [RAW_W-1:0] raw_y;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [OUT_W-1:0] out_x;
      logic signed [OUT_W-1:0] out_y;
      logic                    length_limited;
   } rsp_type;

endpackage

>>> hdl/sdrc_div_cell.sv
// one restoring-division step for both axes sharing one divisor
module sdrc_div_cell import sdrc_pkg::*; #(
   parameter int DW    = 15,
   parameter int QW    = 15,
   parameter int SW    = 4,
   parameter bit SHIFT = 1'b1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   vld_in,
   input  logic [1:0][DW-1:0]     rem_in,
   input  logic [1:0][QW-1:0]     quo_in,
   input  logic [DW-1:0]          dvs_in,
   input  logic [SW-1:0]          side_in,
   output logic                   vld_out,
   output logic [1:0][DW-1:0]     rem_out,
   output logic [1:0][QW-1:0]     quo_out,
   output logic [DW-1:0]          dvs_out,
   output logic [SW-1:0]          side_out
);

   logic                vld_ff;
   logic [1:0][DW-1:0]  rem_ff, rem_in_w;
   logic [1:0][QW-1:0]  quo_ff, quo_in_w;
   logic [DW-1:0]       dvs_ff;
   logic [SW-1:0]       side_ff;

   // trial subtract per lane
   always_comb begin
      logic [DW:0] t;
      logic [DW:0] d;
      logic        ge;
      for (int k = 0; k < 2; k++) begin
         t  = SHIFT ? {rem_in[k], 1'b0} : {1'b0, rem_in[k]};
         d  = t - {1'b0, dvs_in};
         ge = (t >= {1'b0, dvs_in});
         rem_in_w[k] = ge ? d[DW-1:0] : t[DW-1:0];
         quo_in_w[k] = {quo_in[k][QW-2:0], ge};
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in_w;
         quo_ff  <= quo_in_w;
         dvs_ff  <= dvs_in;
         side_ff <= side_in;
      end
   end

   assign vld_out  = vld_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;
   assign dvs_out  = dvs_ff;
   assign side_out = side_ff;

endmodule

>>> hdl/sdrc_sqrt_cell.sv
// one digit-by-digit square root step, two radicand bits per cell
module sdrc_sqrt_cell import sdrc_pkg::*; #(
   parameter int NW = 32,
   parameter int RW = 16,
   parameter int SW = 33
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            vld_in,
   input  logic [RW+1:0]   rem_in,
   input  logic [RW-1:0]   root_in,
   input  logic [NW-1:0]   rad_in,
   input  logic [SW-1:0]   side_in,
   output logic            vld_out,
   output logic [RW+1:0]   rem_out,
   output logic [RW-1:0]   root_out,
   output logic [NW-1:0]   rad_out,
   output logic [SW-1:0]   side_out
);

   logic            vld_ff;
   logic [RW+1:0]   rem_ff, rem_in_w;
   logic [RW-1:0]   root_ff, root_in_w;
   logic [NW-1:0]   rad_ff;
   logic [SW-1:0]   side_ff;

   // bring down two bits and try root*4+1
   always_comb begin
      logic [RW+3:0] rn;
      logic [RW+3:0] trial;
      logic [RW+3:0] d;
      logic          ge;
      rn    = {rem_in, rad_in[NW-1:NW-2]};
      trial = {2'b00, root_in, 2'b01};
      d     = rn - trial;
      ge    = (rn >= trial);
      rem_in_w  = ge ? d[RW+1:0] : rn[RW+1:0];
      root_in_w = {root_in[RW-2:0], ge};
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in_w;
         root_ff <= root_in_w;
         rad_ff  <= {rad_in[NW-3:0], 2'b00};
         side_ff <= side_in;
      end
   end

   assign vld_out  = vld_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign rad_out  = rad_ff;
   assign side_out = side_ff;

endmodule

>>> hdl/stick_deadzone_radial_clamp_core.sv
// stick conditioning pipeline: dead zone, clamp, scale and radial limit
// registers: input, divide cells, square, sum, root cells, divide cells, output
// throughput: one beat per cycle unless stalled; the chains of divide and root cells all
// advance together, set by one quotient bit per divide cell and one root bit per root cell
// a stalled rsp beat holds the whole chain; req_ready follows the output register
// reset (synchronous) clears all valid flags and loads dead_zone 3000, full_scale 25000
module stick_deadzone_radial_clamp_core import sdrc_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int QW   = FRAC_BITS + 1;
   localparam int SQW  = 2 * FRAC_BITS + 2;
   localparam int SUMW = 2 * FRAC_BITS + 4;
   localparam int RTW  = FRAC_BITS + 2;
   localparam int SSW  = 3 + 2 * QW;
   localparam logic [SUMW-1:0] ONE_SQ = SUMW'(1) << (2 * FRAC_BITS);
   localparam logic [RTW-1:0]  ONE_L  = RTW'(1) << FRAC_BITS;
   localparam logic [QW-1:0]   ONE_Q  = QW'(1) << FRAC_BITS;

   // configuration registers
   logic [CSR_W-1:0] dead_zone_ff, full_scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff  <= DEAD_ZONE_RESET;
         full_scale_ff <= FULL_SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEAD_ZONE:  dead_zone_ff  <= csr_data;
            CSR_FULL_SCALE: full_scale_ff <= csr_data;
         endcase
      end
   end

   // whole chain moves when the output register can take a beat
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   logic     adv;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // dead zone and clamp of both axes
   logic [1:0][CSR_W-1:0] mag_in;
   logic [1:0]            neg_in, zero_in;

   always_comb begin
      logic [RAW_W-1:0] raw;
      logic [RAW_W:0]   ext;
      logic [RAW_W:0]   ab;
      for (int k = 0; k < 2; k++) begin
         raw = (k == 0) ? req.raw_y : req.raw_x;
         ext = {raw[RAW_W-1], raw};
         ab  = raw[RAW_W-1] ? (-ext) : ext;
         neg_in[k] = raw[RAW_W-1];
         mag_in[k] = (ab > {2'b00, full_scale_ff}) ? full_scale_ff : ab[CSR_W-1:0];
         zero_in[k] = (ab < {2'b00, dead_zone_ff}) || (mag_in[k] == '0);
      end
   end

   logic                  s0_vld_ff;
   logic [1:0][CSR_W-1:0] s0_mag_ff;
   logic [1:0]            s0_neg_ff, s0_zero_ff;
   logic [CSR_W-1:0]      s0_fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_mag_ff  <= mag_in;
         s0_neg_ff  <= neg_in;
         s0_zero_ff <= zero_in;
         s0_fs_ff   <= full_scale_ff;
      end
   end

   // scale divide: mag * 2^F / full_scale, one quotient bit per cell
   logic                  d1_vld  [0:QW];
   logic [1:0][CSR_W-1:0] d1_rem  [0:QW];
   logic [1:0][QW-1:0]    d1_quo  [0:QW];
   logic [CSR_W-1:0]      d1_dvs  [0:QW];
   logic [3:0]            d1_side [0:QW];

   assign d1_vld[0]  = s0_vld_ff;
   assign d1_rem[0]  = s0_mag_ff;
   assign d1_quo[0]  = '0;
   assign d1_dvs[0]  = s0_fs_ff;
   assign d1_side[0] = {s0_neg_ff, s0_zero_ff};

   for (genvar i = 0; i < QW; i++) begin : g_div1
      sdrc_div_cell #(
         .DW(CSR_W), .QW(QW), .SW(4), .SHIFT(i != 0)
      ) u_cell (
         .clock(clock), .reset(reset), .en(adv),
         .vld_in(d1_vld[i]), .rem_in(d1_rem[i]), .quo_in(d1_quo[i]),
         .dvs_in(d1_dvs[i]), .side_in(d1_side[i]),
         .vld_out(d1_vld[i+1]), .rem_out(d1_rem[i+1]), .quo_out(d1_quo[i+1]),
         .dvs_out(d1_dvs[i+1]), .side_out(d1_side[i+1])
      );
   end

   // squares of the scaled magnitudes
   logic [1:0][QW-1:0] sc_a;
   logic               sq_vld_ff;
   logic [1:0][QW-1:0] sq_a_ff;
   logic [1:0][SQW-1:0] sq_p_ff;
   logic [1:0]         sq_neg_ff;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         sc_a[k] = d1_side[QW][k] ? '0 : d1_quo[QW][k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else if (adv) begin
         sq_vld_ff <= d1_vld[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_a_ff   <= sc_a;
         sq_neg_ff <= d1_side[QW][3:2];
         for (int k = 0; k < 2; k++) begin
            sq_p_ff[k] <= {{(SQW-QW){1'b0}}, sc_a[k]} * {{(SQW-QW){1'b0}}, sc_a[k]};
         end
      end
   end

   // squared length and limit decision
   logic               sm_vld_ff;
   logic [SUMW-1:0]    sm_s_ff, sum_in;
   logic               sm_lim_ff;
   logic [1:0][QW-1:0] sm_a_ff;
   logic [1:0]         sm_neg_ff;

   assign sum_in = {2'b00, sq_p_ff[0]} + {2'b00, sq_p_ff[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_vld_ff <= 1'b0;
      end else if (adv) begin
         sm_vld_ff <= sq_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_s_ff   <= sum_in;
         sm_lim_ff <= (sum_in > ONE_SQ);
         sm_a_ff   <= sq_a_ff;
         sm_neg_ff <= sq_neg_ff;
      end
   end

   // square root of the squared length, one root bit per cell
   logic               rt_vld  [0:RTW];
   logic [RTW+1:0]     rt_rem  [0:RTW];
   logic [RTW-1:0]     rt_root [0:RTW];
   logic [SUMW-1:0]    rt_rad  [0:RTW];
   logic [SSW-1:0]     rt_side [0:RTW];

   assign rt_vld[0]  = sm_vld_ff;
   assign rt_rem[0]  = '0;
   assign rt_root[0] = '0;
   assign rt_rad[0]  = sm_s_ff;
   assign rt_side[0] = {sm_neg_ff, sm_lim_ff, sm_a_ff};

   for (genvar i = 0; i < RTW; i++) begin : g_sqrt
      sdrc_sqrt_cell #(
         .NW(SUMW), .RW(RTW), .SW(SSW)
      ) u_cell (
         .clock(clock), .reset(reset), .en(adv),
         .vld_in(rt_vld[i]), .rem_in(rt_rem[i]), .root_in(rt_root[i]),
         .rad_in(rt_rad[i]), .side_in(rt_side[i]),
         .vld_out(rt_vld[i+1]), .rem_out(rt_rem[i+1]), .root_out(rt_root[i+1]),
         .rad_out(rt_rad[i+1]), .side_out(rt_side[i+1])
      );
   end

   // renormalize divide: a * 2^F / length
   logic                d2_vld  [0:QW];
   logic [1:0][RTW-1:0] d2_rem  [0:QW];
   logic [1:0][QW-1:0]  d2_quo  [0:QW];
   logic [RTW-1:0]      d2_dvs  [0:QW];
   logic [SSW-1:0]      d2_side [0:QW];
   logic [1:0][QW-1:0]  rt_a;

   assign rt_a = rt_side[RTW][2*QW-1:0];

   assign d2_vld[0]  = rt_vld[RTW];
   assign d2_rem[0]  = {{1'b0, rt_a[1]}, {1'b0, rt_a[0]}};
   assign d2_quo[0]  = '0;
   assign d2_dvs[0]  = rt_root[RTW];
   assign d2_side[0] = rt_side[RTW];

   for (genvar i = 0; i < QW; i++) begin : g_div2
      sdrc_div_cell #(
         .DW(RTW), .QW(QW), .SW(SSW), .SHIFT(i != 0)
      ) u_cell (
         .clock(clock), .reset(reset), .en(adv),
         .vld_in(d2_vld[i]), .rem_in(d2_rem[i]), .quo_in(d2_quo[i]),
         .dvs_in(d2_dvs[i]), .side_in(d2_side[i]),
         .vld_out(d2_vld[i+1]), .rem_out(d2_rem[i+1]), .quo_out(d2_quo[i+1]),
         .dvs_out(d2_dvs[i+1]), .side_out(d2_side[i+1])
      );
   end

   // sign restore and output register
   logic               fin_lim;
   logic [1:0]         fin_neg;
   logic [1:0][QW-1:0] fin_a;
   rsp_type            rsp_in;

   assign fin_lim = d2_side[QW][2*QW];
   assign fin_neg = d2_side[QW][2*QW+2:2*QW+1];
   assign fin_a   = d2_side[QW][2*QW-1:0];

   always_comb begin
      logic [QW-1:0]      m;
      logic [QW:0]        sv;
      logic [QW+OUT_W:0]  ext;
      logic [1:0][OUT_W-1:0] o;
      for (int k = 0; k < 2; k++) begin
         m   = fin_lim ? d2_quo[QW][k] : fin_a[k];
         sv  = fin_neg[k] ? ((QW+1)'(0) - {1'b0, m}) : {1'b0, m};
         ext = {{OUT_W{sv[QW]}}, sv};
         o[k] = ext[OUT_W-1:0];
      end
      rsp_in.out_x          = o[1];
      rsp_in.out_y          = o[0];
      rsp_in.length_limited = fin_lim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d2_vld[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // checks
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("rsp valid set after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(s0_vld_ff) && $stable(sm_vld_ff) && $stable(rsp_ff)))
      else $error("pipeline moved during stall");

   a_root_min: assert property (@(posedge clock) disable iff (reset)
      (rt_vld[RTW] && rt_side[RTW][2*QW]) |-> (rt_root[RTW] >= ONE_L))
      else $error("length below one on a limited beat");

   a_quo_max: assert property (@(posedge clock) disable iff (reset)
      (d2_vld[QW] && fin_lim) |-> (d2_quo[QW][0] <= ONE_Q && d2_quo[QW][1] <= ONE_Q))
      else $error("renormalized axis above one");

endmodule

>>> dv/testbench.sv
// self-checking testbench for the stick dead-zone and radial clamp core
`timescale 1ns / 100ps

module testbench;
   import sdrc_pkg::*;

   localparam int FRAC = 14;
   localparam int PIPE_LAT = 3*FRAC + 8;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_DEAD_ZONE;
   logic [CSR_W-1:0] csr_data = '0;

   stick_deadzone_radial_clamp_core #(.FRAC_BITS(FRAC)) dut (.*);

   // local copy of the registers
   logic [CSR_W-1:0] dz_reg = DEAD_ZONE_RESET;
   logic [CSR_W-1:0] fs_reg = FULL_SCALE_RESET;

   rsp_type pending_rsp[$];
   int mismatch_cnt = 0;
   longint cycle_cnt = 0;
   bit calm = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   // dead zone, clamp and Q scaling of one axis
   function automatic longint shape(logic signed [RAW_W-1:0] v);
      longint mag;
      longint q;
      mag = (v < 0) ? -longint'(v) : longint'(v);
      if (mag < longint'(dz_reg)) return 0;
      if (mag > longint'(fs_reg)) mag = fs_reg;
      if (fs_reg == 0 || mag == 0) return 0;
      q = (mag << FRAC) / longint'(fs_reg);
      return (v < 0) ? -q : q;
   endfunction

   function automatic longint int_sqrt(longint n);
      longint res;
      longint b;
      res = 0;
      b = longint'(1) << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic rsp_type condition_stick(req_type s);
      longint qx;
      longint qy;
      longint sq;
      longint len;
      rsp_type r;
      qx = shape(s.raw_x);
      qy = shape(s.raw_y);
      sq = qx*qx + qy*qy;
      r.length_limited = 1'b0;
      if (sq > (longint'(1) << (2*FRAC))) begin
         len = int_sqrt(sq);
         qx = (qx < 0) ? -(((-qx) << FRAC) / len) : ((qx << FRAC) / len);
         qy = (qy < 0) ? -(((-qy) << FRAC) / len) : ((qy << FRAC) / len);
         r.length_limited = 1'b1;
      end
      r.out_x = qx[OUT_W-1:0];
      r.out_y = qy[OUT_W-1:0];
      return r;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // receiver stalls and result check
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               mismatch_cnt <= mismatch_cnt + 1;
               if (mismatch_cnt < 10) $display("unexpected rsp beat %p", rsp);
            end else begin
               if (rsp !== pending_rsp[0]) begin
                  mismatch_cnt <= mismatch_cnt + 1;
                  if (mismatch_cnt < 10)
                     $display("mismatch: expected %p actual %p", pending_rsp[0], rsp);
               end
               void'(pending_rsp.pop_front());
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 16);
      end
   end

   // valid stays high between back-to-back beats and drops only while idling
   task automatic send_sample(logic signed [RAW_W-1:0] x, logic signed [RAW_W-1:0] y);
      req_type s;
      while (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      s.raw_x = x;
      s.raw_y = y;
      req <= s;
      req_valid <= 1'b1;
      pending_rsp.push_back(condition_stick(s));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DEAD_ZONE) dz_reg = val; else fs_reg = val;
      @(posedge clock);
   endtask

   task automatic send_random(int n);
      int k;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(3) == 0)
            send_sample(16'($urandom), 16'($urandom));
         else
            send_sample(16'($signed($urandom_range(2*fs_reg + 6)) - fs_reg - 3),
                        16'($signed($urandom_range(2*fs_reg + 6)) - fs_reg - 3));
      end
   endtask

   // extremes, dead-zone edges and most negative input at reset settings
   task automatic test_directed();
      send_sample(0, 0);
      send_sample(16'sh7fff, 0);
      send_sample(-16'sh8000, 0);
      send_sample(0, -16'sh8000);
      send_sample(-16'sh8000, -16'sh8000);
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(2999, -2999);
      send_sample(3000, -3000);
      send_sample(25000, 0);
      send_sample(-25000, 25000);
      send_sample(17000, 17000);
      send_sample(17677, 17677);
      send_sample(-1, 1);
      send_sample(16'sh5555, -16'sh2aab);
   endtask

   // register extremes, including zero full scale
   task automatic test_register_sweep();
      write_reg(CSR_FULL_SCALE, 0);
      send_sample(16'sh7fff, -16'sh8000);
      send_sample(100, 0);
      send_random(20);
      drain();
      write_reg(CSR_DEAD_ZONE, 0);
      write_reg(CSR_FULL_SCALE, 1);
      send_sample(0, 0);
      send_sample(1, -1);
      send_sample(-16'sh8000, 16'sh7fff);
      send_random(30);
      drain();
      write_reg(CSR_DEAD_ZONE, 15'h7fff);
      write_reg(CSR_FULL_SCALE, 15'h7fff);
      send_sample(16'sh7ffe, 0);
      send_sample(16'sh7fff, -16'sh8000);
      send_random(30);
      drain();
   endtask

   // random samples across several settings
   task automatic test_random();
      int ph;
      for (ph = 0; ph < 8; ph++) begin
         write_reg(CSR_DEAD_ZONE, 15'($urandom_range(6000)));
         write_reg(CSR_FULL_SCALE, 15'($urandom_range(32767, 1)));
         calm = (ph == 3);
         send_random(130);
         calm = 1'b0;
         drain();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      test_register_sweep();
      test_random();
      if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
